// ===== sv/pkd_pkg.sv =====
// pkd_pkg: shared types, codes and helpers for the packed pattern decoder
// used by pkd_parser and packed_pattern_decoder; no dependencies
`timescale 1ns / 1ps

package pkd_pkg;

  // parse phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_LEN_HI = 9'b000000010,
    PH_FLAG   = 9'b000000100,
    PH_NOTE   = 9'b000001000,
    PH_INSTR  = 9'b000010000,
    PH_VOL    = 9'b000100000,
    PH_FXCODE = 9'b001000000,
    PH_FXVAL  = 9'b010000000,
    PH_DONE   = 9'b100000000
  } pkd_phase_t;

  // note kinds
  localparam logic [1:0] NOTE_ABSENT = 2'd0;
  localparam logic [1:0] NOTE_PITCH  = 2'd1;
  localparam logic [1:0] NOTE_EMPTY  = 2'd2;
  localparam logic [1:0] NOTE_CUT    = 2'd3;

  // event kinds
  localparam logic KIND_NOTE    = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // special note bytes and flag bits
  localparam logic [7:0] NOTE_BYTE_EMPTY = 8'd255;
  localparam logic [7:0] NOTE_BYTE_CUT   = 8'd254;
  localparam logic [7:0] VOLUME_MAX      = 8'd64;
  localparam int FLAG_NOTE_BIT = 5;
  localparam int FLAG_VOL_BIT  = 6;
  localparam int FLAG_FX_BIT   = 7;

  typedef struct packed {
    logic       event_kind;
    logic [4:0] channel;
    logic [5:0] row;
    logic [1:0] note_kind;
    logic [7:0] note_pitch;
    logic [7:0] instrument;
    logic       volume_present;
    logic [6:0] volume;
    logic       effect_present;
    logic [7:0] effect_code;
    logic [7:0] effect_value;
    logic       pattern_end;
  } pkd_result_t;

  // octave * 12 + semitone, octave in the high nibble
  function automatic logic [7:0] pkd_pitch(input logic [7:0] b);
    logic [7:0] oct;
    oct = {4'd0, b[7:4]};
    return (oct << 3) + (oct << 2) + {4'd0, b[3:0]};
  endfunction

endpackage

// ===== sv/packed_pattern_decoder.sv =====
// packed_pattern_decoder: top level, input register, parser and result register
// depends on pkd_pkg and pkd_parser
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   in_data_byte, in_start_of_pattern
// out_      output     out_valid/out_stall event fields, one transaction per result
//
// one byte per cycle sustained while out_stall is low; a byte's result passes from
// the input register through the parser logic into the result register
// synchronous active-low reset returns the parser to idle awaiting a start mark
// a stalled result holds the output register; the input register still takes one
// transaction, then in_stall rises until the result is taken
// bytes that complete no event produce no output transaction

module packed_pattern_decoder
  import pkd_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_pattern,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_event_kind,
  output logic [4:0] out_channel,
  output logic [5:0] out_row,
  output logic [1:0] out_note_kind,
  output logic [7:0] out_note_pitch,
  output logic [7:0] out_instrument,
  output logic       out_volume_present,
  output logic [6:0] out_volume,
  output logic       out_effect_present,
  output logic [7:0] out_effect_code,
  output logic [7:0] out_effect_value,
  output logic       out_pattern_end
);

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;

  // result register
  logic        out_valid_r;
  pkd_result_t out_res_r;

  // parser outputs
  logic        p_valid;
  pkd_result_t p_res;

  logic        out_free;
  logic        s1_fire;

  // the result register can take a new value when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // the held byte moves through the parser only when its result has a place
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_start_of_pattern;
    end
  end

  pkd_parser #(
    .ROWS(ROWS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(s1_fire),
    .item_start(s1_start_r),
    .item_byte (s1_byte_r),
    .res_valid (p_valid),
    .res       (p_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && p_valid;
    end
  end

  // payload only loads on a new result so a stalled transaction holds
  always_ff @(posedge clk) begin
    if (out_free && s1_fire && p_valid) begin
      out_res_r <= p_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_res_r.event_kind;
  assign out_channel        = out_res_r.channel;
  assign out_row            = out_res_r.row;
  assign out_note_kind      = out_res_r.note_kind;
  assign out_note_pitch     = out_res_r.note_pitch;
  assign out_instrument     = out_res_r.instrument;
  assign out_volume_present = out_res_r.volume_present;
  assign out_volume         = out_res_r.volume;
  assign out_effect_present = out_res_r.effect_present;
  assign out_effect_code    = out_res_r.effect_code;
  assign out_effect_value   = out_res_r.effect_value;
  assign out_pattern_end    = out_res_r.pattern_end;

endmodule

// ===== sv/pkd_parser.sv =====
// pkd_parser: parse state and next-state logic for one byte per cycle
// depends on pkd_pkg
`timescale 1ns / 1ps

module pkd_parser
  import pkd_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  logic        item_start,
  input  logic [7:0]  item_byte,
  output logic        res_valid,
  output pkd_result_t res
);

  localparam int ROW_W = $clog2(ROWS + 1);
  localparam int ROW_X = (ROW_W > 6) ? ROW_W : 6;

  pkd_phase_t       phase_r, phase_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [16:0]      br_r, br_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       flag_r, flag_nxt;
  logic [1:0]       nkind_r, nkind_nxt;
  logic [7:0]       pitch_r, pitch_nxt;
  logic [7:0]       instr_r, instr_nxt;
  logic [6:0]       vol_r, vol_nxt;
  logic [7:0]       fxc_r, fxc_nxt;

  logic [16:0]      br_p1, br_p2, len_x;
  logic [ROW_W-1:0] row_p1;
  logic             keep_b1, keep_b2, keep_row;
  logic             ev_fire, ev_keep;
  logic [7:0]       ev_fx;
  logic [ROW_X-1:0] row_ext;

  assign br_p1    = br_r + 17'd1;
  assign br_p2    = br_r + 17'd2;
  assign len_x    = {1'b0, len_r};
  assign row_p1   = row_r + ROW_W'(1);
  assign keep_b1  = (row_r < ROW_W'(ROWS)) && (br_p1 <= len_x);
  assign keep_b2  = (row_r < ROW_W'(ROWS)) && (br_p2 <= len_x);
  assign keep_row = (row_p1 < ROW_W'(ROWS)) && (br_p1 <= len_x);
  assign row_ext  = ROW_X'(row_r);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    br_nxt    = br_r;
    row_nxt   = row_r;
    flag_nxt  = flag_r;
    nkind_nxt = nkind_r;
    pitch_nxt = pitch_r;
    instr_nxt = instr_r;
    vol_nxt   = vol_r;
    fxc_nxt   = fxc_r;
    ev_fire   = 1'b0;
    ev_keep   = 1'b0;
    ev_fx     = 8'd0;
    res_valid = 1'b0;
    res       = '0;

    if (item_valid) begin
      if (item_start) begin
        phase_nxt = PH_LEN_HI;
        len_nxt   = {8'd0, item_byte};
        br_nxt    = '0;
        row_nxt   = '0;
        flag_nxt  = '0;
      end else begin
        unique case (phase_r)
          PH_LEN_HI: begin
            len_nxt[15:8] = item_byte;
            br_nxt        = '0;
            row_nxt       = '0;
            phase_nxt     = PH_FLAG;
          end
          PH_FLAG: begin
            br_nxt   = br_p1;
            flag_nxt = item_byte;
            if (item_byte == 8'd0) begin
              row_nxt = row_p1;
              if (!keep_row) begin
                // row limit or length reached on a row advance
                res_valid       = 1'b1;
                res.event_kind  = KIND_END;
                res.pattern_end = 1'b1;
                phase_nxt       = PH_DONE;
              end
            end else if (item_byte[FLAG_NOTE_BIT]) begin
              phase_nxt = PH_NOTE;
            end else if (item_byte[FLAG_VOL_BIT]) begin
              phase_nxt = PH_VOL;
            end else if (item_byte[FLAG_FX_BIT]) begin
              phase_nxt = PH_FXCODE;
            end else begin
              ev_fire = 1'b1;
              ev_keep = keep_b1;
            end
          end
          PH_NOTE: begin
            if (item_byte == NOTE_BYTE_EMPTY) begin
              nkind_nxt = NOTE_EMPTY;
              pitch_nxt = 8'd0;
            end else if (item_byte == NOTE_BYTE_CUT) begin
              nkind_nxt = NOTE_CUT;
              pitch_nxt = 8'd0;
            end else begin
              nkind_nxt = NOTE_PITCH;
              pitch_nxt = pkd_pitch(item_byte);
            end
            phase_nxt = PH_INSTR;
          end
          PH_INSTR: begin
            instr_nxt = item_byte - 8'd1;
            br_nxt    = br_p2;
            if (flag_r[FLAG_VOL_BIT]) begin
              phase_nxt = PH_VOL;
            end else if (flag_r[FLAG_FX_BIT]) begin
              phase_nxt = PH_FXCODE;
            end else begin
              ev_fire = 1'b1;
              ev_keep = keep_b2;
            end
          end
          PH_VOL: begin
            vol_nxt = (item_byte > VOLUME_MAX) ? VOLUME_MAX[6:0] : item_byte[6:0];
            br_nxt  = br_p1;
            if (flag_r[FLAG_FX_BIT]) begin
              phase_nxt = PH_FXCODE;
            end else begin
              ev_fire = 1'b1;
              ev_keep = keep_b1;
            end
          end
          PH_FXCODE: begin
            fxc_nxt   = item_byte - 8'd1;
            phase_nxt = PH_FXVAL;
          end
          PH_FXVAL: begin
            br_nxt  = br_p2;
            ev_fire = 1'b1;
            ev_keep = keep_b2;
            ev_fx   = item_byte;
          end
          PH_IDLE, PH_DONE: begin
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    if (ev_fire) begin
      res_valid          = 1'b1;
      res.event_kind     = KIND_NOTE;
      res.channel        = flag_nxt[4:0];
      res.row            = row_ext[5:0];
      if (flag_nxt[FLAG_NOTE_BIT]) begin
        res.note_kind  = nkind_nxt;
        res.note_pitch = (nkind_nxt == NOTE_PITCH) ? pitch_nxt : 8'd0;
        res.instrument = instr_nxt;
      end
      if (flag_nxt[FLAG_VOL_BIT]) begin
        res.volume_present = 1'b1;
        res.volume         = vol_nxt;
      end
      if (flag_nxt[FLAG_FX_BIT]) begin
        res.effect_present = 1'b1;
        res.effect_code    = fxc_nxt;
        res.effect_value   = ev_fx;
      end
      res.pattern_end    = !ev_keep;
      phase_nxt          = ev_keep ? PH_FLAG : PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      br_r    <= '0;
      row_r   <= '0;
      flag_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      br_r    <= br_nxt;
      row_r   <= row_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // held event parts, always written before use
  always_ff @(posedge clk) begin
    nkind_r <= nkind_nxt;
    pitch_r <= pitch_nxt;
    instr_r <= instr_nxt;
    vol_r   <= vol_nxt;
    fxc_r   <= fxc_nxt;
  end

endmodule

// ===== tb/sv/pkd_event_check.sv =====
// pkd_event_check: watches both channels of packed_pattern_decoder, predicts each
// decoded event from the accepted bytes and compares it with the result transactions
// depends on pkd_pkg
`timescale 1ns / 1ps

module pkd_event_check
  import pkd_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_pattern,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_event_kind,
  input  logic [4:0] out_channel,
  input  logic [5:0] out_row,
  input  logic [1:0] out_note_kind,
  input  logic [7:0] out_note_pitch,
  input  logic [7:0] out_instrument,
  input  logic       out_volume_present,
  input  logic [6:0] out_volume,
  input  logic       out_effect_present,
  input  logic [7:0] out_effect_code,
  input  logic [7:0] out_effect_value,
  input  logic       out_pattern_end,
  output int         mismatches,
  output int         outstanding
);

  // decoder state as this side tracks it
  pkd_phase_t  phase;
  logic [15:0] pat_len;
  logic [16:0] bytes_seen;
  logic [8:0]  row_cnt;
  logic [7:0]  cur_flag;
  logic [1:0]  held_note;
  logic [7:0]  held_pitch;
  logic [7:0]  held_instr;
  logic [6:0]  held_vol;
  logic [7:0]  held_fx;

  pkd_result_t events_q [$];
  int          err_cnt = 0;

  function automatic void clear_state();
    phase      = PH_IDLE;
    pat_len    = '0;
    bytes_seen = '0;
    row_cnt    = '0;
    cur_flag   = '0;
    held_note  = NOTE_ABSENT;
    held_pitch = '0;
    held_instr = '0;
    held_vol   = '0;
    held_fx    = '0;
  endfunction

  function automatic bit more_to_read();
    return (row_cnt < ROWS) && (bytes_seen <= {1'b0, pat_len});
  endfunction

  // builds the event for the current flag and moves on or finishes the pattern
  function automatic pkd_result_t close_event(input logic [7:0] fx_val);
    pkd_result_t r;
    r = '0;
    r.event_kind = KIND_NOTE;
    r.channel    = cur_flag[4:0];
    r.row        = row_cnt[5:0];
    if (cur_flag[FLAG_NOTE_BIT]) begin
      r.note_kind  = held_note;
      r.note_pitch = (held_note == NOTE_PITCH) ? held_pitch : 8'd0;
      r.instrument = held_instr;
    end
    if (cur_flag[FLAG_VOL_BIT]) begin
      r.volume_present = 1'b1;
      r.volume         = held_vol;
    end
    if (cur_flag[FLAG_FX_BIT]) begin
      r.effect_present = 1'b1;
      r.effect_code    = held_fx;
      r.effect_value   = fx_val;
    end
    r.pattern_end = !more_to_read();
    phase = r.pattern_end ? PH_DONE : PH_FLAG;
    return r;
  endfunction

  // one accepted byte; queues the event it completes, if any
  function automatic void decode_byte(input logic [7:0] b, input logic sop);
    pkd_result_t r;
    bit          emit;
    r    = '0;
    emit = 1'b0;
    if (sop) begin
      clear_state();
      pat_len = {8'd0, b};
      phase   = PH_LEN_HI;
    end else begin
      case (phase)
        PH_LEN_HI: begin
          pat_len[15:8] = b;
          bytes_seen    = '0;
          row_cnt       = '0;
          phase         = PH_FLAG;
        end
        PH_FLAG: begin
          bytes_seen = bytes_seen + 17'd1;
          cur_flag   = b;
          if (b == 8'd0) begin
            row_cnt = row_cnt + 9'd1;
            if (!more_to_read()) begin
              r.event_kind  = KIND_END;
              r.pattern_end = 1'b1;
              emit          = 1'b1;
              phase         = PH_DONE;
            end
          end else if (b[FLAG_NOTE_BIT]) begin
            phase = PH_NOTE;
          end else if (b[FLAG_VOL_BIT]) begin
            phase = PH_VOL;
          end else if (b[FLAG_FX_BIT]) begin
            phase = PH_FXCODE;
          end else begin
            r    = close_event(8'd0);
            emit = 1'b1;
          end
        end
        PH_NOTE: begin
          if (b == NOTE_BYTE_EMPTY) begin
            held_note  = NOTE_EMPTY;
            held_pitch = 8'd0;
          end else if (b == NOTE_BYTE_CUT) begin
            held_note  = NOTE_CUT;
            held_pitch = 8'd0;
          end else begin
            held_note  = NOTE_PITCH;
            held_pitch = 8'(b[7:4]) * 8'd12 + 8'(b[3:0]);
          end
          phase = PH_INSTR;
        end
        PH_INSTR: begin
          held_instr = b - 8'd1;
          bytes_seen = bytes_seen + 17'd2;
          if (cur_flag[FLAG_VOL_BIT]) begin
            phase = PH_VOL;
          end else if (cur_flag[FLAG_FX_BIT]) begin
            phase = PH_FXCODE;
          end else begin
            r    = close_event(8'd0);
            emit = 1'b1;
          end
        end
        PH_VOL: begin
          held_vol   = (b > VOLUME_MAX) ? VOLUME_MAX[6:0] : b[6:0];
          bytes_seen = bytes_seen + 17'd1;
          if (cur_flag[FLAG_FX_BIT]) begin
            phase = PH_FXCODE;
          end else begin
            r    = close_event(8'd0);
            emit = 1'b1;
          end
        end
        PH_FXCODE: begin
          held_fx = b - 8'd1;
          phase   = PH_FXVAL;
        end
        PH_FXVAL: begin
          bytes_seen = bytes_seen + 17'd2;
          r          = close_event(b);
          emit       = 1'b1;
        end
        default: begin
          // idle or finished: byte is dropped
        end
      endcase
    end
    if (emit) events_q.push_back(r);
  endfunction

  function automatic string field_diffs(input pkd_result_t w, input pkd_result_t g);
    string s;
    s = "";
    if (g.event_kind     !== w.event_kind)     s = {s, " event_kind"};
    if (g.channel        !== w.channel)        s = {s, " channel"};
    if (g.row            !== w.row)            s = {s, " row"};
    if (g.note_kind      !== w.note_kind)      s = {s, " note_kind"};
    if (g.note_pitch     !== w.note_pitch)     s = {s, " note_pitch"};
    if (g.instrument     !== w.instrument)     s = {s, " instrument"};
    if (g.volume_present !== w.volume_present) s = {s, " volume_present"};
    if (g.volume         !== w.volume)         s = {s, " volume"};
    if (g.effect_present !== w.effect_present) s = {s, " effect_present"};
    if (g.effect_code    !== w.effect_code)    s = {s, " effect_code"};
    if (g.effect_value   !== w.effect_value)   s = {s, " effect_value"};
    if (g.pattern_end    !== w.pattern_end)    s = {s, " pattern_end"};
    return s;
  endfunction

  always @(posedge clk) begin
    pkd_result_t seen;
    pkd_result_t want;
    string       diffs;
    if (!rst_n) begin
      clear_state();
      events_q.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // result side first: a byte accepted now cannot show up on this edge
      if (out_valid && !out_stall) begin
        seen = {out_event_kind, out_channel, out_row, out_note_kind, out_note_pitch,
                out_instrument, out_volume_present, out_volume, out_effect_present,
                out_effect_code, out_effect_value, out_pattern_end};
        if (events_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("pkd_event_check: unexpected result %p", seen);
        end else begin
          want  = events_q.pop_front();
          diffs = field_diffs(want, seen);
          if (diffs != "") begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("pkd_event_check: mismatch in%s\n  exp %p\n  act %p",
                       diffs, want, seen);
          end
        end
      end
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_start_of_pattern);
      mismatches  <= err_cnt;
      outstanding <= events_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// tb: stimulus and verdict for packed_pattern_decoder; events are checked by
// pkd_event_check placed beside the block; depends on pkd_pkg and both modules
`timescale 1ns / 1ps

module tb;

  localparam int ROWS      = 64;
  localparam int ITEMS     = 900;
  localparam int LIMIT     = 300000;   // cycles, far above the slowest clean run

  logic       clk                 = 1'b0;
  logic       rst_n               = 1'b0;
  logic       in_valid            = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte        = 8'd0;
  logic       in_start_of_pattern = 1'b0;
  logic       out_valid;
  logic       out_stall           = 1'b0;
  logic       out_event_kind;
  logic [4:0] out_channel;
  logic [5:0] out_row;
  logic [1:0] out_note_kind;
  logic [7:0] out_note_pitch;
  logic [7:0] out_instrument;
  logic       out_volume_present;
  logic [6:0] out_volume;
  logic       out_effect_present;
  logic [7:0] out_effect_code;
  logic [7:0] out_effect_value;
  logic       out_pattern_end;

  int   mismatches;
  int   outstanding;
  int   fed  = 0;        // bytes sent, apart from the trailing bytes after each random pattern
  logic calm = 1'b0;     // high during the stretch where neither side idles

  always #5 clk = ~clk;

  packed_pattern_decoder #(.ROWS(ROWS)) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_pattern(in_start_of_pattern),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_channel        (out_channel),
    .out_row            (out_row),
    .out_note_kind      (out_note_kind),
    .out_note_pitch     (out_note_pitch),
    .out_instrument     (out_instrument),
    .out_volume_present (out_volume_present),
    .out_volume         (out_volume),
    .out_effect_present (out_effect_present),
    .out_effect_code    (out_effect_code),
    .out_effect_value   (out_effect_value),
    .out_pattern_end    (out_pattern_end)
  );

  pkd_event_check #(.ROWS(ROWS)) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_pattern(in_start_of_pattern),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_channel        (out_channel),
    .out_row            (out_row),
    .out_note_kind      (out_note_kind),
    .out_note_pitch     (out_note_pitch),
    .out_instrument     (out_instrument),
    .out_volume_present (out_volume_present),
    .out_volume         (out_volume),
    .out_effect_present (out_effect_present),
    .out_effect_code    (out_effect_code),
    .out_effect_value   (out_effect_value),
    .out_pattern_end    (out_pattern_end),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // receiver stalls at random, about 9 percent of the time, never during the calm stretch
  always @(posedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 9);
  end

  // one input transaction; random idle cycles go in front of it
  // the payload stays put while the decoder stalls
  task automatic feed(input logic [7:0] b, input logic sop, input bit counted);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data_byte        <= b;
    in_start_of_pattern <= sop;
    if (counted) fed++;
    calm <= (fed >= 250) && (fed < 420);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender stops and waits until every predicted event has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // well-formed pattern with random content; the loop ends exactly where the
  // decoder is expected to finish (row limit, or bytes past the length)
  // cut_at > 0 abandons the pattern after that many bytes, so the next start
  // mark lands in the middle of it
  task automatic play_pattern(input logic [15:0] len, input int row_pct, input int cut_at);
    logic [7:0] ev [$];
    logic [7:0] flag;
    int         rows;
    int         used;
    int         sent;
    rows = 0;
    used = 0;
    sent = 1;
    feed(len[7:0], 1'b1, 1'b1);
    if (sent == cut_at) return;
    feed(len[15:8], 1'b0, 1'b1);
    sent++;
    if (sent == cut_at) return;
    while (rows < ROWS && used <= int'(len)) begin
      ev.delete();
      if ($urandom_range(99) < row_pct) begin
        flag = 8'h00;
        rows++;
      end else begin
        flag = 8'($urandom_range(1, 255));
      end
      ev.push_back(flag);
      used++;
      if (flag[5]) begin
        // note byte: empty, cut, or any pitch byte
        case ($urandom_range(3))
          0:       ev.push_back(8'hFF);
          1:       ev.push_back(8'hFE);
          default: ev.push_back(8'($urandom_range(255)));
        endcase
        ev.push_back(8'($urandom_range(255)));
        used += 2;
      end
      if (flag[6]) begin
        // volume around the clamp point half the time
        ev.push_back($urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(60, 70)));
        used++;
      end
      if (flag[7]) begin
        ev.push_back(8'($urandom_range(255)));
        ev.push_back(8'($urandom_range(255)));
        used += 2;
      end
      foreach (ev[i]) begin
        feed(ev[i], 1'b0, 1'b1);
        sent++;
        if (sent == cut_at) return;
      end
    end
  endtask

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin
    logic [8:0]  directed [$];   // {start mark, data byte}
    logic [15:0] len;
    int          pick;
    int          row_pct;
    int          cut_at;
    bit          paused;
    directed = '{
      9'h0_FF,                                       // byte before any start: dropped
      9'h1_0C, 9'h0_00,                              // length 12
      9'h0_3F, 9'h0_00, 9'h0_00,                     // ch 31, pitch 0, instrument wraps to 255
      9'h0_01,                                       // flag without data bits: bare event
      9'h0_EA, 9'h0_FE, 9'h0_01, 9'h0_FF, 9'h0_00, 9'h0_FF, // cut, vol clamp, fx code wraps
      9'h0_00,                                       // next row
      9'h0_C5, 9'h0_40, 9'h0_01, 9'h0_80,            // runs past the length inside the event
      9'h0_55,                                       // after the end: dropped
      9'h1_00, 9'h0_00, 9'h0_00,                     // zero length: first row flag ends it
      9'h1_FF, 9'h0_FF, 9'h0_A0, 9'h0_FD             // max length, abandoned mid-event
    };
    paused = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) feed(directed[i][7:0], directed[i][8], 1'b1);

    // random part: mostly well-formed patterns, some noise and cut-off patterns
    while (fed < ITEMS) begin
      if (!paused && fed >= 500) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        // raw noise, start marks included
        repeat ($urandom_range(1, 4))
          feed(8'($urandom_range(255)), ($urandom_range(3) == 0), 1'b1);
      end else begin
        if (pick < 70) begin
          len     = 16'($urandom_range(48));
          row_pct = 15;
        end else if (pick < 92) begin
          // long length, so the row limit ends the pattern
          len     = 16'($urandom_range(300, 65535));
          row_pct = 80;
        end else begin
          len     = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(49, 299));
          row_pct = 60;
        end
        cut_at = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : 0;
        play_pattern(len, row_pct, cut_at);
        // trailing bytes, normally dropped by a finished decoder
        repeat ($urandom_range(2)) feed(8'($urandom_range(255)), 1'b0, 1'b0);
      end
    end

    drain();
    // let anything stray from the pipeline show up
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
